// ===== rtl/date_difference_days_top_assert.svh =====
// assertion macros for the date difference block
`ifndef DATE_DIFFERENCE_DAYS_TOP_ASSERT_SVH
`define DATE_DIFFERENCE_DAYS_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define DDD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define DDD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dtdiff_pkg.sv =====
package dtdiff_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned SpanW  = 22;
  localparam int unsigned OrdW   = 23;
  localparam int unsigned Q100W  = 8;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 24;

  localparam logic [YearW-1:0]  YearMax  = 14'd9999;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;
  localparam logic [SpanW-1:0]  SpanMax  = 22'd3652058;

  // x / 100 == (x * 5243) >> 19 for every 14-bit x
  localparam logic [12:0] Div100Mul   = 13'd5243;
  localparam int unsigned Div100Shift = 19;
  localparam int unsigned ProdW       = YearW + 13;

  typedef struct packed {
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
  } date_t;

  // days in a month of a common year, 0 for codes that are no month
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:                                        len = 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  // days of a common year that come before the month
  function automatic logic [8:0] days_before(input logic [MonthW-1:0] m);
    logic [8:0] n;
    case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/date_difference_days_top.sv =====
// throughput: one date pair per cycle; each stage holds its item while the
//   next stage is full and stalled, so a stall loses or repeats nothing
// reset: rst_ni clears all stage valid bits asynchronously; data regs keep junk
// stages: reciprocal multiplies, year day count and leap test, ordinals, span
module date_difference_days_top import dtdiff_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // first_day[4:0] first_month[8:5] first_year[22:9]
  // second_day[27:23] second_month[31:28] second_year[45:32], zero pad [47:46]
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // day_span[21:0], zero pad [23:22]
  output logic [OutDataW-1:0] m_axis_tdata_o,
  // dates_valid[0]
  output logic                m_axis_tuser_o
);

  // ---------------------------------------------------------------------
  // stage enables: a stage loads when it is empty or its successor moves
  // ---------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || m_axis_tready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign s_axis_tready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // unpack the two dates from the input word
  date_t in_date [2];

  assign in_date[0].day   = s_axis_tdata_i[4:0];
  assign in_date[0].month = s_axis_tdata_i[8:5];
  assign in_date[0].year  = s_axis_tdata_i[22:9];
  assign in_date[1].day   = s_axis_tdata_i[27:23];
  assign in_date[1].month = s_axis_tdata_i[31:28];
  assign in_date[1].year  = s_axis_tdata_i[45:32];

  // ---------------------------------------------------------------------
  // stage 1: multiply year and year-1 by the reciprocal of 100
  // ---------------------------------------------------------------------
  date_t            s1_date_q [2];
  logic [YearW-1:0] s1_prev_q [2];
  logic [ProdW-1:0] s1_qy_q   [2];
  logic [ProdW-1:0] s1_qp_q   [2];

  logic [YearW-1:0] s1_prev_d [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      // year 0 wraps here; such a date is invalid and its count unused
      s1_prev_d[i] = in_date[i].year - YearW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      for (int i = 0; i < 2; i++) begin
        s1_date_q[i] <= in_date[i];
        s1_prev_q[i] <= s1_prev_d[i];
        s1_qy_q[i]   <= ProdW'(in_date[i].year) * ProdW'(Div100Mul);
        s1_qp_q[i]   <= ProdW'(s1_prev_d[i]) * ProdW'(Div100Mul);
      end
    end
  end

  // ---------------------------------------------------------------------
  // stage 2: leap test, date checks, days before 1 January of the year
  // ---------------------------------------------------------------------
  logic [Q100W-1:0] y100      [2];
  logic [Q100W-1:0] p100      [2];
  logic             leap_d    [2];
  logic             ok_d      [2];
  logic [DayW-1:0]  mlen      [2];
  logic [OrdW-1:0]  ydays_d   [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      y100[i] = s1_qy_q[i][Div100Shift +: Q100W];
      p100[i] = s1_qp_q[i][Div100Shift +: Q100W];
      // divisible by 4, and not by 100 unless also by 400
      leap_d[i] = (s1_date_q[i].year[1:0] == 2'b00) &&
                  ((15'(y100[i]) * 15'd100 != 15'(s1_date_q[i].year)) ||
                   (y100[i][1:0] == 2'b00));
      mlen[i] = month_len(s1_date_q[i].month);
      if (s1_date_q[i].month == MonthFeb && leap_d[i]) begin
        mlen[i] = 5'd29;
      end
      ok_d[i] = (s1_date_q[i].year != '0) && (s1_date_q[i].year <= YearMax) &&
                (s1_date_q[i].month != '0) && (s1_date_q[i].month <= MonthDec) &&
                (s1_date_q[i].day != '0) && (s1_date_q[i].day <= mlen[i]);
      ydays_d[i] = OrdW'(s1_prev_q[i]) * OrdW'(365)
                 + OrdW'(s1_prev_q[i][YearW-1:2])
                 - OrdW'(p100[i])
                 + OrdW'(p100[i][Q100W-1:2]);
    end
  end

  logic [DayW-1:0]   s2_day_q   [2];
  logic [MonthW-1:0] s2_month_q [2];
  logic              s2_leap_q  [2];
  logic [OrdW-1:0]   s2_ydays_q [2];
  logic              s2_ok_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      for (int i = 0; i < 2; i++) begin
        s2_day_q[i]   <= s1_date_q[i].day;
        s2_month_q[i] <= s1_date_q[i].month;
        s2_leap_q[i]  <= leap_d[i];
        s2_ydays_q[i] <= ydays_d[i];
      end
      s2_ok_q <= ok_d[0] && ok_d[1];
    end
  end

  // ---------------------------------------------------------------------
  // stage 3: day ordinals, 1 January of year 1 counts as day 1
  // ---------------------------------------------------------------------
  logic [OrdW-1:0] ord_d [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      ord_d[i] = s2_ydays_q[i] + OrdW'(days_before(s2_month_q[i]))
               + OrdW'(s2_day_q[i])
               + OrdW'(s2_leap_q[i] && (s2_month_q[i] > MonthFeb));
    end
  end

  logic [OrdW-1:0] s3_ord_q [2];
  logic            s3_ok_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_ord_q[0] <= ord_d[0];
      s3_ord_q[1] <= ord_d[1];
      s3_ok_q     <= s2_ok_q;
    end
  end

  // ---------------------------------------------------------------------
  // stage 4: absolute difference, forced to zero for an invalid pair
  // ---------------------------------------------------------------------
  logic [OrdW-1:0]  diff_d;
  logic [SpanW-1:0] span_d;

  always_comb begin
    if (s3_ord_q[0] > s3_ord_q[1]) begin
      diff_d = s3_ord_q[0] - s3_ord_q[1];
    end else begin
      diff_d = s3_ord_q[1] - s3_ord_q[0];
    end
    span_d = s3_ok_q ? diff_d[SpanW-1:0] : '0;
  end

  logic [SpanW-1:0] s4_span_q;
  logic             s4_ok_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      s4_span_q <= span_d;
      s4_ok_q   <= s3_ok_q;
    end
  end

  assign m_axis_tvalid_o = v4_q;
  assign m_axis_tdata_o  = {(OutDataW - SpanW)'(0), s4_span_q};
  assign m_axis_tuser_o  = s4_ok_q;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
`include "date_difference_days_top_assert.svh"

  `DDD_ASSERT_NOW(a_invalid_zero, v4_q && !s4_ok_q, s4_span_q == '0, "invalid pair with nonzero span")
  `DDD_ASSERT_NOW(a_span_bound, v4_q, s4_span_q <= SpanMax, "span beyond the largest date distance")
  `DDD_ASSERT_NOW(a_ready_when_empty, !v4_q, s_axis_tready_o, "input blocked with an empty output stage")
  `DDD_ASSERT_NEXT(a_no_drop, v3_q && v4_q && !m_axis_tready_i, v3_q, "stage 3 item lost during a stall")

endmodule

// ===== tb/date_difference_days_top_test.sv =====
module date_difference_days_top_test import dtdiff_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles with no transfer on either side before the run is given up
  localparam int unsigned StallLimit = 2000;
  // cycles to wait after the last result, more than the pipeline depth
  localparam int unsigned SettleCycles = 10;
  // random date pairs in each of the three random phases
  localparam int unsigned PhaseItems = 280;

  // expected day spans in transfer order, plus the calendar arithmetic
  class span_board;
    typedef struct {
      logic [SpanW-1:0] span;
      logic             valid;
    } span_exp_t;

    span_exp_t   owed[$];
    int unsigned fails;

    function new();
      fails = 0;
    endfunction

    static function bit leap_year(int unsigned y);
      return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    // length of a month in a given year, 0 for a code that is no month
    static function int unsigned month_days(int unsigned m, int unsigned y);
      case (m)
        2:                    return leap_year(y) ? 29 : 28;
        4, 6, 9, 11:          return 30;
        1, 3, 5, 7, 8, 10, 12: return 31;
        default:              return 0;
      endcase
    endfunction

    static function bit date_legal(date_t d);
      int unsigned y;
      int unsigned len;
      y   = int'(d.year);
      len = month_days(int'(d.month), y);
      if (y < 1 || y > int'(YearMax)) return 1'b0;
      return (len != 0) && (d.day >= 1) && (int'(d.day) <= len);
    endfunction

    // day count with 1 january of year 1 as day 1
    static function int unsigned day_number(date_t d);
      int unsigned prior;
      int unsigned n;
      prior = int'(d.year) - 1;
      n = 365 * prior + prior / 4 - prior / 100 + prior / 400;
      for (int unsigned m = 1; m < int'(d.month); m++) begin
        n += month_days(m, int'(d.year));
      end
      return n + int'(d.day);
    endfunction

    function void note_pair(date_t a, date_t b);
      span_exp_t   e;
      int unsigned na;
      int unsigned nb;
      e.valid = date_legal(a) && date_legal(b);
      e.span  = '0;
      if (e.valid) begin
        na = day_number(a);
        nb = day_number(b);
        e.span = (na > nb) ? SpanW'(na - nb) : SpanW'(nb - na);
      end
      owed.push_back(e);
    endfunction

    function void check_result(logic [OutDataW-1:0] data, logic flag);
      span_exp_t e;
      if (owed.size() == 0) begin
        $error("result transfer with no date pair outstanding: tdata %h", data);
        fails++;
        return;
      end
      e = owed.pop_front();
      if (data[SpanW-1:0] !== e.span) begin
        $error("day_span mismatch: expected %0d, actual %0d", e.span, data[SpanW-1:0]);
        fails++;
      end
      if (data[OutDataW-1:SpanW] !== '0) begin
        $error("pad mismatch: expected 0, actual %0d", data[OutDataW-1:SpanW]);
        fails++;
      end
      if (flag !== e.valid) begin
        $error("dates_valid mismatch: expected %0d, actual %0d", e.valid, flag);
        fails++;
      end
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;

  // random gaps on the sender side and stalls on the receiver side
  bit          tx_gaps = 1'b1;
  bit          rx_stalls = 1'b1;
  int unsigned quiet_cycles = 0;
  span_board   board = new();

  date_difference_days_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // receiver: tready changes on the falling edge, about 15 stalls in 100
  always @(negedge clk_i) begin
    m_axis_tready <= !(rx_stalls && ($urandom_range(99) < 15));
  end

  // every result transfer is checked against the oldest expected span
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  // watchdog: too long without a transfer on either side ends the run
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic date_t make_date(int unsigned d, int unsigned m, int unsigned y);
    date_t r;
    r.day   = d[DayW-1:0];
    r.month = m[MonthW-1:0];
    r.year  = y[YearW-1:0];
    return r;
  endfunction

  // a legal date, with years near the leap rule edges picked more often
  function automatic date_t legal_date(int unsigned y_fixed);
    int unsigned y;
    int unsigned m;
    int unsigned len;
    int unsigned d;
    int unsigned edge_years[12] = '{1, 2, 4, 100, 400, 1600, 1900, 2000, 2100,
                                    9996, 9998, 9999};
    if (y_fixed != 0) y = y_fixed;
    else if ($urandom_range(99) < 20) y = edge_years[$urandom_range(11)];
    else y = $urandom_range(int'(YearMax), 1);
    m   = $urandom_range(12, 1);
    len = span_board::month_days(m, y);
    d   = ($urandom_range(99) < 25) ? len : $urandom_range(len, 1);
    return make_date(d, m, y);
  endfunction

  // any bit pattern the fields can hold, mostly not a legal date
  function automatic date_t noise_date();
    date_t r;
    r.day   = DayW'($urandom);
    r.month = MonthW'($urandom);
    r.year  = YearW'($urandom);
    return r;
  endfunction

  // one input transfer; entered and left at a falling edge
  task automatic send_pair(date_t a, date_t b);
    while (tx_gaps && ($urandom_range(99) < 15)) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    // second date in the upper half, each date packed day, month, year from bit 0
    s_axis_tdata  <= {2'b00, b.year, b.month, b.day, a.year, a.month, a.day};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_pair(a, b);
    @(negedge clk_i);
  endtask

  task automatic send_dates(int unsigned d1, int unsigned m1, int unsigned y1,
                            int unsigned d2, int unsigned m2, int unsigned y2);
    send_pair(make_date(d1, m1, y1), make_date(d2, m2, y2));
  endtask

  // hold the sender idle until every outstanding span has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic random_phase(int unsigned count);
    date_t a;
    date_t b;
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(99);
      a = legal_date(0);
      if (pick < 60) b = legal_date(0);
      else if (pick < 75) b = legal_date(int'(a.year));
      else if (pick < 85) begin
        b = noise_date();
        if (pick[0]) begin
          b = a;
          a = noise_date();
        end
      end else begin
        a = noise_date();
        b = noise_date();
      end
      send_pair(a, b);
    end
  endtask

  initial begin
    // reset held low at the start, released on a falling edge
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // same date, and the widest legal span in both orders
    send_dates(1, 1, 1, 1, 1, 1);
    send_dates(1, 1, 1, 31, 12, 9999);
    send_dates(31, 12, 9999, 1, 1, 1);
    // february 29 under each branch of the leap rule
    send_dates(29, 2, 2000, 1, 1, 2000);
    send_dates(29, 2, 1900, 1, 1, 1900);
    send_dates(29, 2, 2024, 28, 2, 2023);
    send_dates(29, 2, 2023, 1, 3, 2023);
    // within one year, second date earlier
    send_dates(1, 3, 2024, 28, 2, 2024);
    // invalid month codes
    send_dates(1, 0, 2000, 1, 1, 2000);
    send_dates(1, 1, 2000, 1, 13, 2000);
    send_dates(15, 15, 500, 15, 6, 500);
    // invalid day numbers
    send_dates(0, 5, 1234, 1, 5, 1234);
    send_dates(31, 4, 1234, 1, 5, 1234);
    send_dates(31, 11, 1999, 31, 12, 1999);
    send_dates(30, 2, 2000, 1, 1, 2000);
    // years at and beyond the legal range
    send_dates(1, 1, 0, 1, 1, 1);
    send_dates(1, 1, 9999, 1, 1, 10000);
    send_dates(1, 1, 5000, 31, 15, 16383);
    send_dates(31, 15, 16383, 31, 15, 16383);
    send_dates(0, 0, 0, 0, 0, 0);
    // last days of months late in the year
    send_dates(31, 8, 1, 31, 10, 1);
    send_dates(30, 11, 8191, 31, 12, 8192);

    random_phase(PhaseItems);
    drain_results();

    // long stretch with no gaps and no stalls at all
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    random_phase(PhaseItems);

    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    random_phase(PhaseItems);

    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    if (board.fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
